// File: rtl/pie_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the phase inductance estimator
package pie_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned AMP_W    = 16;
  localparam int unsigned BAND_W   = 10;
  localparam int unsigned SEQ_W    = 3;
  localparam int unsigned IND_W    = 32;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // 2000 * v fits 27 bits, times dt gives 59 bits
  localparam int unsigned VSCALE_W = 27;
  localparam int unsigned NUM_W    = VSCALE_W + TIME_W;
  localparam int unsigned NUMHI_W  = NUM_W - IND_W;
  // 3 * |i| fits 17 bits
  localparam int unsigned DEN_W    = AMP_W + 1;
  localparam int unsigned CNT_W    = 5;

  localparam logic [10:0]        VOLT_SCALE = 11'd2000;
  localparam logic [1:0]         AMP_SCALE  = 2'd3;
  localparam logic [IND_W-1:0]   POS_SAT    = 32'h7FFF_FFFF;
  localparam logic [IND_W-1:0]   NEG_SAT    = 32'h8000_0000;
  localparam logic [CNT_W-1:0]   DIV_LAST   = 5'd31;

  // register indexes of the configuration port
  localparam logic [1:0] REG_BRAKE_DUR   = 2'd0;
  localparam logic [1:0] REG_MEASURE_DUR = 2'd1;
  localparam logic [1:0] REG_ZERO_BAND   = 2'd2;

  typedef enum logic [SEQ_W-1:0] {
    SEQ_IDLE    = 3'd0,
    SEQ_BRAKE   = 3'd1,
    SEQ_MEASURE = 3'd2,
    SEQ_DONE    = 3'd3,
    SEQ_ERROR   = 3'd4
  } seq_t;

endpackage

// File: rtl/pie_in_if.sv
`timescale 1ns / 1ps
// input channel: one control tick sample
interface pie_in_if
  import pie_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        now_us;
  logic [VOLT_W-1:0]        bus_volts_mv;
  logic signed [AMP_W-1:0]  phase_a_current_ma;

  modport source (output valid, now_us, bus_volts_mv, phase_a_current_ma, input ready);
  modport sink   (input valid, now_us, bus_volts_mv, phase_a_current_ma, output ready);
endinterface

// File: rtl/pie_out_if.sv
`timescale 1ns / 1ps
// result channel: leg commands and inductance estimate
interface pie_out_if
  import pie_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [SEQ_W-1:0]         seq_state;
  logic                     leg_a_enable;
  logic                     leg_a_high;
  logic                     leg_b_enable;
  logic                     leg_b_high;
  logic                     leg_c_enable;
  logic                     leg_c_high;
  logic signed [IND_W-1:0]  inductance_nh;
  logic                     inductance_valid;

  modport source (output valid, seq_state, leg_a_enable, leg_a_high, leg_b_enable,
                  leg_b_high, leg_c_enable, leg_c_high, inductance_nh,
                  inductance_valid, input ready);
  modport sink   (input valid, seq_state, leg_a_enable, leg_a_high, leg_b_enable,
                  leg_b_high, leg_c_enable, leg_c_high, inductance_nh,
                  inductance_valid, output ready);
endinterface

// File: rtl/phase_inductance_estimator_unit.sv
`timescale 1ns / 1ps
// phase inductance estimator: brake / voltage step sequencer with serial divider
//
// One input transfer is one control tick (time stamp, bus voltage, phase A current)
// and yields exactly one result transfer with the sequence state, the three bridge
// leg commands and, once the measurement is complete, the inductance estimate
// L = 2000*V*dt / (3*|I|) in nH, sign opposite to the current, saturated to
// 32 bits. A tick that does not land in the complete state goes from the input
// transfer straight to loading the result register. A complete tick is latched,
// passes two multiply steps (2000*V, then times dt), one range check and a
// one-bit-per-cycle restoring divider, and then loads the result register. A
// complete tick with zero current, or with a quotient too large for 32 bits,
// skips the divider. The input is ready only while the core is idle; a finished
// result waits in the output register, so the next tick can be taken while the
// previous result is still pending. Registers are written over an APB-style port
// (brake duration at 0x0, measure duration at 0x4, zero band at 0x8); the user
// must change them only while the block is idle, the block does not enforce it.
module phase_inductance_estimator_unit
  import pie_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  pie_in_if.sink            in_ch,
  pie_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_CHK,
    S_DIV,
    S_OUT
  } core_t;

  // configuration registers
  logic [TIME_W-1:0] brake_dur_r;
  logic [TIME_W-1:0] meas_dur_r;
  logic [BAND_W-1:0] zero_band_r;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brake_dur_r <= '0;
      meas_dur_r  <= '0;
      zero_band_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_BRAKE_DUR:   brake_dur_r <= pwdata;
        REG_MEASURE_DUR: meas_dur_r  <= pwdata;
        REG_ZERO_BAND:   zero_band_r <= pwdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BRAKE_DUR:   prdata = brake_dur_r;
      REG_MEASURE_DUR: prdata = meas_dur_r;
      REG_ZERO_BAND:   prdata = {{(DATA_W-BAND_W){1'b0}}, zero_band_r};
      default:         prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  core_t              core_r, core_nxt;
  seq_t               fsm_r, fsm_nxt;
  logic [TIME_W-1:0]  brake_start_r, brake_start_nxt;
  logic               brake_started_r, brake_started_nxt;
  logic [TIME_W-1:0]  meas_start_r, meas_start_nxt;
  logic               meas_started_r, meas_started_nxt;

  logic [VOLT_W-1:0]   volts_r, volts_nxt;
  logic [AMP_W-1:0]    amag_r, amag_nxt;
  logic                aneg_r, aneg_nxt;
  logic                azero_r, azero_nxt;
  logic [TIME_W-1:0]   dt_r, dt_nxt;
  logic [VSCALE_W-1:0] vscaled_r, vscaled_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [NUMHI_W-1:0]  num_hi_r, num_hi_nxt;
  logic [IND_W-1:0]    num_lo_r, num_lo_nxt;  // low dividend bits, quotient shifts in
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic                sat_r, sat_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  seq_t                out_seq_r, out_seq_nxt;
  logic [IND_W-1:0]    out_ind_r, out_ind_nxt;
  logic                out_ind_valid_r, out_ind_valid_nxt;

  // tick decode
  logic              in_xfer;
  logic              out_xfer;
  logic [AMP_W-1:0]  in_amag;
  logic [TIME_W-1:0] elapsed;
  seq_t              seq_step;
  logic [NUM_W-1:0]  num_full;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_diff;
  logic [IND_W-1:0]  ind_val;

  assign in_ch.ready = (core_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;

  assign in_amag = in_ch.phase_a_current_ma[AMP_W-1]
                 ? (~in_ch.phase_a_current_ma + 1'b1) : in_ch.phase_a_current_ma;
  assign elapsed = in_ch.now_us - ((fsm_r == SEQ_BRAKE) ? brake_start_r : meas_start_r);

  // sequence step from the previous state
  always_comb begin
    case (fsm_r)
      SEQ_IDLE: begin
        if (meas_dur_r == '0)       seq_step = SEQ_ERROR;
        else if (brake_dur_r != '0) seq_step = SEQ_BRAKE;
        else                        seq_step = SEQ_MEASURE;
      end
      SEQ_BRAKE:   seq_step = (elapsed >= brake_dur_r) ? SEQ_MEASURE : SEQ_BRAKE;
      SEQ_MEASURE: begin
        if (elapsed < meas_dur_r) seq_step = SEQ_MEASURE;
        else if ((in_amag > {{(AMP_W-BAND_W){1'b0}}, zero_band_r}) &&
                 (in_ch.bus_volts_mv > {{(VOLT_W-BAND_W){1'b0}}, zero_band_r}))
          seq_step = SEQ_DONE;
        else seq_step = SEQ_ERROR;
      end
      SEQ_DONE:    seq_step = SEQ_DONE;
      default:     seq_step = SEQ_ERROR;
    endcase
  end

  assign num_full   = vscaled_r * dt_r;
  assign trial      = {rem_r, num_lo_r[IND_W-1]};
  assign trial_diff = trial - {1'b0, den_r};

  // final value: quotient in num_lo_r, overflow in sat_r
  always_comb begin
    if (azero_r)      ind_val = POS_SAT;
    else if (aneg_r)  ind_val = (sat_r || num_lo_r > POS_SAT) ? POS_SAT : num_lo_r;
    else              ind_val = (sat_r || num_lo_r > NEG_SAT) ? NEG_SAT : (~num_lo_r + 1'b1);
  end

  always_comb begin
    core_nxt          = core_r;
    fsm_nxt           = fsm_r;
    brake_start_nxt   = brake_start_r;
    brake_started_nxt = brake_started_r;
    meas_start_nxt    = meas_start_r;
    meas_started_nxt  = meas_started_r;
    volts_nxt         = volts_r;
    amag_nxt          = amag_r;
    aneg_nxt          = aneg_r;
    azero_nxt         = azero_r;
    dt_nxt            = dt_r;
    vscaled_nxt       = vscaled_r;
    den_nxt           = den_r;
    num_hi_nxt        = num_hi_r;
    num_lo_nxt        = num_lo_r;
    rem_nxt           = rem_r;
    sat_nxt           = sat_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = out_valid_r && !out_xfer;
    out_seq_nxt       = out_seq_r;
    out_ind_nxt       = out_ind_r;
    out_ind_valid_nxt = out_ind_valid_r;

    case (core_r)
      S_IDLE: begin
        if (in_xfer) begin
          fsm_nxt   = seq_step;
          volts_nxt = in_ch.bus_volts_mv;
          amag_nxt  = in_amag;
          aneg_nxt  = in_ch.phase_a_current_ma[AMP_W-1];
          azero_nxt = (in_ch.phase_a_current_ma == '0);
          dt_nxt    = in_ch.now_us - meas_start_r;
          sat_nxt   = 1'b0;
          // latch phase start on the first tick of the phase
          if (seq_step == SEQ_BRAKE && !brake_started_r) begin
            brake_start_nxt   = in_ch.now_us;
            brake_started_nxt = 1'b1;
          end
          if (seq_step == SEQ_MEASURE && !meas_started_r) begin
            meas_start_nxt   = in_ch.now_us;
            meas_started_nxt = 1'b1;
          end
          core_nxt = (seq_step == SEQ_DONE) ? S_MUL1 : S_OUT;
        end
      end
      S_MUL1: begin
        vscaled_nxt = VSCALE_W'(volts_r * VOLT_SCALE);
        den_nxt     = DEN_W'(amag_r * AMP_SCALE);
        core_nxt    = S_MUL2;
      end
      S_MUL2: begin
        num_hi_nxt = num_full[NUM_W-1:IND_W];
        num_lo_nxt = num_full[IND_W-1:0];
        core_nxt   = S_CHK;
      end
      S_CHK: begin
        if (azero_r) begin
          core_nxt = S_OUT;
        end else if (num_hi_r >= {{(NUMHI_W-DEN_W){1'b0}}, den_r}) begin
          // quotient needs more than 32 bits
          sat_nxt  = 1'b1;
          core_nxt = S_OUT;
        end else begin
          rem_nxt  = num_hi_r[DEN_W-1:0];
          cnt_nxt  = '0;
          core_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt    = trial_diff[DEN_W-1:0];
          num_lo_nxt = {num_lo_r[IND_W-2:0], 1'b1};
        end else begin
          rem_nxt    = trial[DEN_W-1:0];
          num_lo_nxt = {num_lo_r[IND_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) core_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt     = 1'b1;
          out_seq_nxt       = fsm_r;
          out_ind_valid_nxt = (fsm_r == SEQ_DONE);
          out_ind_nxt       = (fsm_r == SEQ_DONE) ? ind_val : '0;
          core_nxt          = S_IDLE;
        end
      end
      default: core_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_r          <= S_IDLE;
      fsm_r           <= SEQ_IDLE;
      brake_start_r   <= '0;
      brake_started_r <= 1'b0;
      meas_start_r    <= '0;
      meas_started_r  <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      core_r          <= core_nxt;
      fsm_r           <= fsm_nxt;
      brake_start_r   <= brake_start_nxt;
      brake_started_r <= brake_started_nxt;
      meas_start_r    <= meas_start_nxt;
      meas_started_r  <= meas_started_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    volts_r         <= volts_nxt;
    amag_r          <= amag_nxt;
    aneg_r          <= aneg_nxt;
    azero_r         <= azero_nxt;
    dt_r            <= dt_nxt;
    vscaled_r       <= vscaled_nxt;
    den_r           <= den_nxt;
    num_hi_r        <= num_hi_nxt;
    num_lo_r        <= num_lo_nxt;
    rem_r           <= rem_nxt;
    sat_r           <= sat_nxt;
    cnt_r           <= cnt_nxt;
    out_seq_r       <= out_seq_nxt;
    out_ind_r       <= out_ind_nxt;
    out_ind_valid_r <= out_ind_valid_nxt;
  end

  // leg commands follow the reported state
  assign out_ch.valid            = out_valid_r;
  assign out_ch.seq_state        = out_seq_r;
  assign out_ch.leg_a_enable     = (out_seq_r == SEQ_BRAKE) || (out_seq_r == SEQ_MEASURE);
  assign out_ch.leg_a_high       = 1'b0;
  assign out_ch.leg_b_enable     = (out_seq_r == SEQ_BRAKE) || (out_seq_r == SEQ_MEASURE);
  assign out_ch.leg_b_high       = (out_seq_r == SEQ_MEASURE);
  assign out_ch.leg_c_enable     = (out_seq_r == SEQ_BRAKE) || (out_seq_r == SEQ_MEASURE);
  assign out_ch.leg_c_high       = (out_seq_r == SEQ_MEASURE);
  assign out_ch.inductance_nh    = out_ind_r;
  assign out_ch.inductance_valid = out_ind_valid_r;

  // complete and error never fall back
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(fsm_r) == SEQ_DONE) |-> fsm_r == SEQ_DONE)
    else $error("complete state left");
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(fsm_r) == SEQ_ERROR) |-> fsm_r == SEQ_ERROR)
    else $error("error state left");
  // divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    core_r == S_DIV |-> rem_r < den_r)
    else $error("divider remainder out of range");
  // an estimate only comes with the complete state
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ind_valid_r) |-> out_seq_r == SEQ_DONE)
    else $error("estimate outside complete state");

endmodule
